@@ src/bfpa_pkg.sv @@
// package for the best-fit partition allocator
// widths of the channel fields, default sizes and request codes; no dependencies
`default_nettype none

package bfpa_pkg;

  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;

  localparam int OPCODE_W = 1;
  localparam int PIDX_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int COUNT_W  = 5;
  localparam int LEFT_W   = 16;

  localparam logic [OPCODE_W-1:0] OP_LOAD    = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_REQUEST = 1'b1;

endpackage

`default_nettype wire

@@ src/bfpa_if.sv @@
// channel interfaces for the best-fit partition allocator: input, result, config
// depends on bfpa_pkg for field widths
`default_nettype none

interface bfpa_item_if;
  logic                          valid;
  logic                          ready;
  logic [bfpa_pkg::OPCODE_W-1:0] opcode;
  logic [bfpa_pkg::PIDX_W-1:0]   partition_index;
  logic [bfpa_pkg::AMOUNT_W-1:0] amount;

  modport source (output valid, opcode, partition_index, amount, input ready);
  modport sink   (input valid, opcode, partition_index, amount, output ready);
endinterface

interface bfpa_result_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [bfpa_pkg::PIDX_W-1:0] chosen_partition;
  logic [bfpa_pkg::LEFT_W-1:0] leftover;

  modport source (output valid, granted, chosen_partition, leftover, input ready);
  modport sink   (input valid, granted, chosen_partition, leftover, output ready);
endinterface

interface bfpa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bfpa_pkg::COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/bfpa_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bfpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/best_fit_partition_allocator_top.sv @@
// top level of the best-fit partition allocator: sequencer, one comparator, size table
// depends on bfpa_pkg, bfpa_if.sv (channel interfaces) and bfpa_ram
//
// usage
//   cfg channel: writes partition_count, the number of partitions searched
//     (entries 0 upward, saturated to MAX_PARTITIONS); always ready, write only
//     while the block is idle
//   item channel: opcode load stores amount as the size of partition_index
//     (indexes past the table are dropped); opcode request asks for amount
//   result channel: one result per request, none per load; granted, the
//     partition chosen and what is left of it, or all zero when refused
// timing
//   a load is written to the size table as it is taken, and the block stays ready
//   a request walks the size table through the single read port of the ram,
//   one entry a cycle, with one shared compare/subtract unit, through the states
//   S_SCAN, S_LAST and S_DONE (only S_DONE with no partitions), then ready again
//   the result sits in an output register; when the receiver stalls, further
//   loads are still taken, and a following request runs its scan but holds
//   its write-back until the previous result has been taken
// reset
//   partition_count goes to 0 and the channels go idle; the size table is not
//   cleared, an entry reads undefined until it is loaded
`default_nettype none

module best_fit_partition_allocator_top #(
  parameter int MAX_PARTITIONS = bfpa_pkg::MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS      = bfpa_pkg::SIZE_BITS_DEF
) (
  input wire logic          clk,
  input wire logic          rst,
  bfpa_item_if.sink         item,
  bfpa_result_if.source     result,
  bfpa_cfg_if.sink          cfg
);

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
  localparam int CMP_W = (SIZE_BITS > bfpa_pkg::AMOUNT_W) ? SIZE_BITS : bfpa_pkg::AMOUNT_W;

  // one-hot sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [bfpa_pkg::COUNT_W-1:0]  partition_count;
  logic [bfpa_pkg::AMOUNT_W-1:0] amount;
  logic [IDX_W-1:0]              rd_idx;
  logic [IDX_W-1:0]              last_idx;
  logic                          cmp_valid;
  logic [IDX_W-1:0]              cmp_idx;
  logic                          found;
  logic [IDX_W-1:0]              best_idx;
  logic [SIZE_BITS-1:0]          best_size;

  logic                          out_valid;
  logic                          out_granted;
  logic [bfpa_pkg::PIDX_W-1:0]   out_partition;
  logic [bfpa_pkg::LEFT_W-1:0]   out_leftover;

  logic [CNT_W-1:0]              count_sat;
  logic                          item_take;
  logic                          is_request;
  logic                          load_ok;
  logic                          out_free;
  logic                          finish;
  logic                          fits;
  logic                          better;
  logic [CMP_W-1:0]              diff;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [SIZE_BITS-1:0]          ram_wdata;
  logic                          ram_re;
  logic [SIZE_BITS-1:0]          ram_rdata;

  // config register, always ready
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      partition_count <= '0;
    end else if (cfg.valid) begin
      partition_count <= cfg.data;
    end
  end

  // searched entries, saturated to the table depth
  assign count_sat = (32'(partition_count) > 32'(MAX_PARTITIONS)) ?
                     CNT_W'(MAX_PARTITIONS) : CNT_W'(partition_count);

  assign item.ready = (state == S_IDLE);
  assign item_take  = item.valid && item.ready;
  assign is_request = (item.opcode == bfpa_pkg::OP_REQUEST);
  assign load_ok    = 32'(item.partition_index) < 32'(MAX_PARTITIONS);

  assign out_free = !out_valid || result.ready;
  assign finish   = (state == S_DONE) && out_free;

  // shared compare/subtract unit
  assign fits   = CMP_W'(ram_rdata) >= CMP_W'(amount);
  assign better = !found || (ram_rdata < best_size);
  assign diff   = CMP_W'(best_size) - CMP_W'(amount);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_take && is_request) begin
          state_next = (count_sat == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_idx == last_idx) begin
          state_next = S_LAST;
        end
      end
      S_LAST: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      if (item_take && is_request) begin
        cmp_valid <= 1'b0;
        found     <= 1'b0;
      end else begin
        cmp_valid <= (state == S_SCAN);
        if (cmp_valid && fits && better) begin
          found <= 1'b1;
        end
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (item_take && is_request) begin
      amount   <= item.amount;
      rd_idx   <= '0;
      last_idx <= IDX_W'(count_sat - CNT_W'(1));
    end else if (state == S_SCAN) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
    if (state == S_SCAN) begin
      cmp_idx <= rd_idx;
    end
    if (cmp_valid && fits && better) begin
      best_idx  <= cmp_idx;
      best_size <= ram_rdata;
    end
  end

  // table write port: loads in idle, write-back of the granted partition at finish
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(item.partition_index);
    ram_wdata = SIZE_BITS'(item.amount);
    if (finish) begin
      ram_we    = found;
      ram_waddr = best_idx;
      ram_wdata = SIZE_BITS'(diff);
    end else if (item_take && !is_request) begin
      ram_we = load_ok;
    end
  end

  assign ram_re = (state == S_SCAN);

  bfpa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_PARTITIONS)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_granted <= found;
      if (found) begin
        out_partition <= bfpa_pkg::PIDX_W'(best_idx);
        out_leftover  <= bfpa_pkg::LEFT_W'(SIZE_BITS'(diff));
      end else begin
        out_partition <= '0;
        out_leftover  <= '0;
      end
    end
  end

  assign result.valid            = out_valid;
  assign result.granted          = out_granted;
  assign result.chosen_partition = out_partition;
  assign result.leftover         = out_leftover;

endmodule

`default_nettype wire
